>>> src/bst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int TOKEN_W         = 16;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_INT    = 4'd1,
    KIND_EQ     = 4'd2,
    KIND_LPAREN = 4'd3,
    KIND_RPAREN = 4'd4,
    KIND_LBRACE = 4'd5,
    KIND_RBRACE = 4'd6,
    KIND_COLON  = 4'd7,
    KIND_LT     = 4'd8,
    KIND_GT     = 4'd9,
    KIND_END    = 4'd10,
    KIND_ERROR  = 4'd11
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [TOKEN_W-1:0] start;
    logic [TOKEN_W-1:0] length;
  } token_t;

  // one queue entry holds every token caused by one byte
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

endpackage

`default_nettype wire

>>> src/bst_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bst_front #(
  parameter int OFFSET_BITS = bst_pkg::OFFSET_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire logic [7:0]      in_char_code,
  input  wire logic            q_full,
  output logic                 q_push,
  output bst_pkg::entry_t      q_entry
);
  import bst_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_IDENT = 3'b010,
    MODE_INT   = 3'b100
  } mode_t;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_LP  = 8'h28;
  localparam logic [7:0] CH_RP  = 8'h29;
  localparam logic [7:0] CH_LB  = 8'h7B;
  localparam logic [7:0] CH_RB  = 8'h7D;
  localparam logic [7:0] CH_COL = 8'h3A;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;

  localparam logic [OFFSET_BITS-1:0] CNT_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

  mode_t                  mode_r, mode_nxt, cls;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] len_r, len_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic                   halted_r, halted_nxt;

  logic                   accept;
  logic                   flush;
  logic                   is_ws;
  logic                   is_punct;
  kind_t                  punct_kind;
  logic                   has_b;
  token_t                 tok_run, tok_b;
  logic [OFFSET_BITS-1:0] offset_inc, len_inc;
  logic [TOKEN_W-1:0]     start_w, len_w, offset_w;

  generate
    if (OFFSET_BITS >= TOKEN_W) begin : g_trunc
      assign start_w  = start_r[TOKEN_W-1:0];
      assign len_w    = len_r[TOKEN_W-1:0];
      assign offset_w = offset_r[TOKEN_W-1:0];
    end else begin : g_ext
      assign start_w  = {{(TOKEN_W-OFFSET_BITS){1'b0}}, start_r};
      assign len_w    = {{(TOKEN_W-OFFSET_BITS){1'b0}}, len_r};
      assign offset_w = {{(TOKEN_W-OFFSET_BITS){1'b0}}, offset_r};
    end
  endgenerate

  assign offset_inc = (offset_r == {OFFSET_BITS{1'b1}}) ? offset_r : offset_r + CNT_ONE;
  assign len_inc    = (len_r == {OFFSET_BITS{1'b1}}) ? len_r : len_r + CNT_ONE;

  always_comb begin
    case (in_char_code) inside
      [8'h41:8'h5A], [8'h61:8'h7A]: cls = MODE_IDENT;
      [8'h30:8'h39]:                cls = MODE_INT;
      default:                      cls = MODE_IDLE;
    endcase
  end

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = KIND_ERROR;
    case (in_char_code)
      CH_EQ:   punct_kind = KIND_EQ;
      CH_LP:   punct_kind = KIND_LPAREN;
      CH_RP:   punct_kind = KIND_RPAREN;
      CH_LB:   punct_kind = KIND_LBRACE;
      CH_RB:   punct_kind = KIND_RBRACE;
      CH_COL:  punct_kind = KIND_COLON;
      CH_LT:   punct_kind = KIND_LT;
      CH_GT:   punct_kind = KIND_GT;
      default: is_punct   = 1'b0;
    endcase
  end

  assign is_ws  = (in_char_code inside {CH_CR, CH_LF, CH_SP, CH_TAB});
  assign accept = in_push & ~q_full;
  assign flush  = (mode_r != MODE_IDLE) && (mode_r != cls);

  assign tok_run.kind   = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_INT;
  assign tok_run.start  = start_w;
  assign tok_run.length = len_w;

  always_comb begin
    has_b        = 1'b0;
    tok_b.kind   = KIND_ERROR;
    tok_b.start  = offset_w;
    tok_b.length = TOKEN_W'(1);
    if (cls == MODE_IDLE) begin
      if (in_char_code == CH_NUL) begin
        has_b        = 1'b1;
        tok_b.kind   = KIND_END;
        tok_b.length = '0;
      end else if (!is_ws) begin
        has_b      = 1'b1;
        tok_b.kind = is_punct ? punct_kind : KIND_ERROR;
      end
    end
  end

  assign q_push         = accept & ~halted_r & (flush | has_b);
  assign q_entry.first  = flush ? tok_run : tok_b;
  assign q_entry.second = tok_b;
  assign q_entry.two    = flush & has_b;

  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    offset_nxt = offset_r;
    halted_nxt = halted_r;
    if (accept && !halted_r) begin
      if (flush) begin
        mode_nxt = MODE_IDLE;
        len_nxt  = '0;
      end
      if (cls != MODE_IDLE) begin
        if (mode_r == cls) begin
          len_nxt = len_inc;
        end else begin
          mode_nxt  = cls;
          start_nxt = offset_r;
          len_nxt   = CNT_ONE;
        end
        offset_nxt = offset_inc;
      end else if (in_char_code == CH_NUL) begin
        mode_nxt   = MODE_IDLE;
        start_nxt  = '0;
        len_nxt    = '0;
        offset_nxt = '0;
      end else begin
        offset_nxt = offset_inc;
        if (!is_ws && !is_punct) begin
          halted_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      start_r  <= '0;
      len_r    <= '0;
      offset_r <= '0;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      offset_r <= offset_nxt;
      halted_r <= halted_nxt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !q_push)
    else $error("token written while halted");

endmodule

`default_nettype wire

>>> src/bst_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bst_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bst_pkg::entry_t  wr_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output bst_pkg::entry_t       rd_entry
);
  import bst_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign rd_entry = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

endmodule

`default_nettype wire

>>> src/bst_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bst_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire bst_pkg::entry_t  q_entry,
  output logic                  q_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [3:0]            out_token_kind,
  output logic [15:0]           out_token_start,
  output logic [15:0]           out_token_length,
  output logic                  out_last_of_item
);
  import bst_pkg::*;

  logic   phase_r, phase_nxt;
  logic   xfer;
  token_t tok;

  // phase 0 shows the first token of the head entry, phase 1 the second
  assign tok              = phase_r ? q_entry.second : q_entry.first;
  assign out_empty        = q_empty;
  assign out_token_kind   = tok.kind;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.length;
  assign out_last_of_item = phase_r | ~q_entry.two;

  assign xfer  = out_pop & ~q_empty;
  assign q_pop = xfer & out_last_of_item;

  always_comb begin
    phase_nxt = phase_r;
    if (xfer) begin
      phase_nxt = ~out_last_of_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (!q_empty && q_entry.two))
    else $error("second phase without a two-token entry");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r && !out_pop) |=> phase_r)
    else $error("second token dropped while stalled");

endmodule

`default_nettype wire

>>> src/byte_stream_tokenizer.sv
// Byte stream tokenizer.
// Input channel: in_char_code is taken at a clock edge with in_push high and
// in_full low, one source byte per transfer; a zero byte marks the end of the
// source and restarts the offset count at zero.
// Result channel: while out_empty is low the oldest token sits on out_token_*
// and out_last_of_item; it leaves at an edge with out_pop high.
// out_last_of_item marks the final token caused by one input byte.
// A token enters the queue at the edge that takes the byte causing it.
// Throughput: one byte per cycle while in_full is low; the result side moves
// one token per cycle while out_pop is high and out_empty is low, so a byte
// that closes a run and makes a token of its own yields two tokens. A queue
// of four entries (at most one per byte) between classifier and output fills
// when the receiver stalls and then raises in_full; no byte or token is lost.
// After an error token every further byte is taken and dropped until reset.
// Reset (rst_n low, synchronous) empties the queue and clears all run state.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer #(
  parameter int OFFSET_BITS = bst_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [7:0]  in_char_code,
  output logic             in_full,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_item
);
  import bst_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wr_entry, q_rd_entry;

  assign in_full = q_full;

  bst_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_wr_entry)
  );

  bst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .rd_entry (q_rd_entry)
  );

  bst_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_entry          (q_rd_entry),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_item (out_last_of_item)
  );

endmodule

`default_nettype wire
